// ===== rtl/hcg_pkg.sv =====
// Shared types and constants of the hold-to-confirm guard.
`default_nettype none

package hcg_pkg;

   localparam int unsigned TIME_W     = 32;
   localparam int unsigned DUR_W      = 16;
   localparam int unsigned PROG_W     = 10;
   localparam int unsigned FULL_SCALE = 1000;

   // The quotient of a tick is below FULL_SCALE, which fits the progress field.
   localparam int unsigned QUO_W  = PROG_W;
   localparam int unsigned PROD_W = DUR_W + QUO_W;
   localparam int unsigned CNT_W  = $clog2(QUO_W + 1);

   localparam logic [PROG_W-1:0] FULL_LEVEL = PROG_W'(FULL_SCALE);

   typedef enum logic [2:0] {
      CMD_RESET   = 3'd0,
      CMD_PRESS   = 3'd1,
      CMD_ARM     = 3'd2,
      CMD_TICK    = 3'd3,
      CMD_RELEASE = 3'd4,
      CMD_CANCEL  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_PRESSED   = 3'd1,
      PH_ARMED     = 3'd2,
      PH_COMMITTED = 3'd3,
      PH_CANCELLED = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      OUT_NONE      = 2'd0,
      OUT_TAP       = 2'd1,
      OUT_COMMITTED = 2'd2,
      OUT_CANCELLED = 2'd3
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_EXEC   = 2'd1,
      ST_DIV    = 2'd2,
      ST_FINISH = 2'd3
   } ctl_type;

   typedef struct packed {
      logic [2:0]        command;
      logic [TIME_W-1:0] now_ms;
      logic [DUR_W-1:0]  guard_duration;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [1:0]        release_outcome;
      logic [PROG_W-1:0] progress;
      logic [2:0]        phase_now;
      logic              terminal;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/hold_to_confirm_guard.sv =====
// Top level of the hold-to-confirm guard: event sequencer, guard state and result register.
//
// Usage: each item on the req_ channel is one button event (reset, press, arm,
// tick, release or cancel) with a wrapping millisecond timestamp; a press also
// carries the guard duration. Every item yields exactly one item on the rsp_
// channel with the accepted flag, the release outcome, the progress in permille,
// the phase after the event and a terminal flag.
// Both channels use valid/ready. The block works on one item at a time: most
// events go from the EXEC state straight to the result register, and the next item
// is taken only back in the idle state, after the result is registered. A tick
// or a release that finds the guard armed and not yet expired runs the progress
// division elapsed*FULL_SCALE/duration in a bit-serial divider, one quotient
// bit per cycle, and that item passes through the DIV and FINISH states before
// its result is registered.
// The next item is taken as soon as the previous result is in the output
// register, so a result can wait there while the next event is evaluated.
// If the receiver stalls, the next result waits in the sequencer until the
// output register drains, and req_ready stays low meanwhile.
// Reset (synchronous, active high) returns the guard to idle with zero
// progress, empties the output register and readies the input at once.
`default_nettype none

module hold_to_confirm_guard (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire hcg_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output hcg_pkg::rsp_type     rsp_data
);

   hcg_pkg::ctl_type                ctl_ff, ctl_in;
   hcg_pkg::phase_type              phase_ff, phase_in;
   logic [hcg_pkg::TIME_W-1:0]      armed_time_ff, armed_time_in;
   logic [hcg_pkg::DUR_W-1:0]       hold_limit_ff, hold_limit_in;
   logic [hcg_pkg::PROG_W-1:0]      progress_ff, progress_in;
   hcg_pkg::req_type                item_ff;
   hcg_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   logic                            rsp_valid_ff;

   logic [hcg_pkg::TIME_W-1:0]      elapsed;
   logic                            expired;
   logic                            need_div;
   logic                            acc;
   hcg_pkg::outcome_type            outcome;
   logic                            out_free;
   logic                            apply;
   logic                            div_start;
   logic                            div_done;
   logic [hcg_pkg::QUO_W-1:0]       div_quo;
   logic [hcg_pkg::PROD_W-1:0]      dividend;

   // Elapsed time wraps with the timestamp. When the hold has not expired the
   // elapsed time is below the 16-bit duration, so only its low half is scaled.
   assign elapsed  = item_ff.now_ms - armed_time_ff;
   assign expired  = elapsed >= hcg_pkg::TIME_W'(hold_limit_ff);
   assign dividend = hcg_pkg::PROD_W'(elapsed[hcg_pkg::DUR_W-1:0])
                   * hcg_pkg::PROD_W'(hcg_pkg::FULL_SCALE);

   hcg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (hold_limit_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Effect of the held event on the guard state. Where a division is needed
   // the divider quotient is used; it is only applied once the divider is done.
   always_comb begin
      phase_in      = phase_ff;
      armed_time_in = armed_time_ff;
      hold_limit_in = hold_limit_ff;
      progress_in   = progress_ff;
      acc           = 1'b0;
      outcome       = hcg_pkg::OUT_NONE;
      need_div      = 1'b0;
      unique case (item_ff.command)
         hcg_pkg::CMD_RESET: begin
            phase_in      = hcg_pkg::PH_IDLE;
            armed_time_in = '0;
            hold_limit_in = '0;
            progress_in   = '0;
         end
         hcg_pkg::CMD_PRESS: begin
            if (phase_ff == hcg_pkg::PH_IDLE) begin
               phase_in      = hcg_pkg::PH_PRESSED;
               armed_time_in = '0;
               hold_limit_in = item_ff.guard_duration;
               progress_in   = '0;
               acc           = 1'b1;
            end
         end
         hcg_pkg::CMD_ARM: begin
            if (phase_ff == hcg_pkg::PH_PRESSED) begin
               armed_time_in = item_ff.now_ms;
               acc           = 1'b1;
               if (hold_limit_ff == '0) begin
                  phase_in    = hcg_pkg::PH_COMMITTED;
                  progress_in = hcg_pkg::FULL_LEVEL;
               end else begin
                  phase_in    = hcg_pkg::PH_ARMED;
                  progress_in = '0;
               end
            end
         end
         hcg_pkg::CMD_TICK: begin
            if (phase_ff == hcg_pkg::PH_ARMED) begin
               if (expired) begin
                  phase_in    = hcg_pkg::PH_COMMITTED;
                  progress_in = hcg_pkg::FULL_LEVEL;
                  acc         = 1'b1;
               end else begin
                  need_div    = 1'b1;
                  progress_in = div_quo;
                  acc         = div_quo != progress_ff;
               end
            end
         end
         hcg_pkg::CMD_RELEASE: begin
            if (phase_ff == hcg_pkg::PH_PRESSED) begin
               phase_in      = hcg_pkg::PH_IDLE;
               armed_time_in = '0;
               hold_limit_in = '0;
               progress_in   = '0;
               outcome       = hcg_pkg::OUT_TAP;
            end else if (phase_ff == hcg_pkg::PH_ARMED) begin
               if (expired) begin
                  phase_in    = hcg_pkg::PH_COMMITTED;
                  progress_in = hcg_pkg::FULL_LEVEL;
                  outcome     = hcg_pkg::OUT_COMMITTED;
               end else begin
                  need_div    = 1'b1;
                  phase_in    = hcg_pkg::PH_CANCELLED;
                  progress_in = div_quo;
                  outcome     = hcg_pkg::OUT_CANCELLED;
               end
            end else if (phase_ff == hcg_pkg::PH_COMMITTED) begin
               outcome = hcg_pkg::OUT_COMMITTED;
            end
         end
         hcg_pkg::CMD_CANCEL: begin
            if (phase_ff == hcg_pkg::PH_PRESSED || phase_ff == hcg_pkg::PH_ARMED) begin
               phase_in = hcg_pkg::PH_CANCELLED;
               acc      = 1'b1;
            end
         end
         default: begin
         end
      endcase

      rsp_data_in.accepted        = acc;
      rsp_data_in.release_outcome = outcome;
      rsp_data_in.progress        = progress_in;
      rsp_data_in.phase_now       = phase_in;
      rsp_data_in.terminal        = (phase_in == hcg_pkg::PH_COMMITTED)
                                 || (phase_in == hcg_pkg::PH_CANCELLED);
   end

   // Sequencer: take an item, evaluate it, divide if needed, then commit the
   // new state and the result together once the output register is free.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ctl_in    = ctl_ff;
      req_ready = 1'b0;
      div_start = 1'b0;
      apply     = 1'b0;
      unique case (ctl_ff)
         hcg_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl_in = hcg_pkg::ST_EXEC;
            end
         end
         hcg_pkg::ST_EXEC: begin
            if (need_div) begin
               div_start = 1'b1;
               ctl_in    = hcg_pkg::ST_DIV;
            end else if (out_free) begin
               apply  = 1'b1;
               ctl_in = hcg_pkg::ST_IDLE;
            end
         end
         hcg_pkg::ST_DIV: begin
            if (div_done) begin
               ctl_in = hcg_pkg::ST_FINISH;
            end
         end
         hcg_pkg::ST_FINISH: begin
            if (out_free) begin
               apply  = 1'b1;
               ctl_in = hcg_pkg::ST_IDLE;
            end
         end
         default: begin
            ctl_in = hcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff        <= hcg_pkg::ST_IDLE;
         phase_ff      <= hcg_pkg::PH_IDLE;
         armed_time_ff <= '0;
         hold_limit_ff <= '0;
         progress_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ctl_ff <= ctl_in;
         if (apply) begin
            phase_ff      <= phase_in;
            armed_time_ff <= armed_time_in;
            hold_limit_ff <= hold_limit_in;
            progress_ff   <= progress_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
      if (apply) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // An armed guard always has a nonzero duration, so the divisor is never zero.
   a_armed_nonzero_limit: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hcg_pkg::PH_ARMED |-> hold_limit_ff != '0)
      else $error("armed phase with zero hold limit");

   // The divider is only started for an armed guard whose hold has not expired.
   a_div_start_armed: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (phase_ff == hcg_pkg::PH_ARMED) && !expired)
      else $error("divider started outside an unexpired armed hold");

   // After the divider finishes, its quotient stays below full scale.
   a_quotient_range: assert property (@(posedge clock) disable iff (reset)
      ctl_ff == hcg_pkg::ST_FINISH |-> div_done
         && (hcg_pkg::PROG_W'(div_quo) < hcg_pkg::FULL_LEVEL))
      else $error("quotient out of range after division");

   // Stored progress never exceeds full scale.
   a_progress_bound: assert property (@(posedge clock) disable iff (reset)
      progress_ff <= hcg_pkg::FULL_LEVEL)
      else $error("progress above full scale");
`endif

endmodule

`default_nettype wire

// ===== rtl/hcg_div.sv =====
// Bit-serial restoring divider that yields the progress quotient one bit per cycle.
`default_nettype none

module hcg_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hcg_pkg::PROD_W-1:0] dividend,
   input  wire logic [hcg_pkg::DUR_W-1:0]  divisor,
   output logic                            done,
   output logic [hcg_pkg::QUO_W-1:0]       quotient
);

   logic [hcg_pkg::DUR_W-1:0] rem_ff,  rem_in;
   logic [hcg_pkg::DUR_W-1:0] dvs_ff,  dvs_in;
   logic [hcg_pkg::QUO_W-1:0] sh_ff,   sh_in;
   logic [hcg_pkg::CNT_W-1:0] cnt_ff,  cnt_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [hcg_pkg::DUR_W:0]   trial;
   logic [hcg_pkg::DUR_W:0]   diff;
   logic                      fits;

   // The shift register holds the dividend bits still to be brought down
   // at its top and the quotient bits found so far at its bottom.
   always_comb begin
      trial   = {rem_ff, sh_ff[hcg_pkg::QUO_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      fits    = trial >= {1'b0, dvs_ff};
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         rem_in  = dividend[hcg_pkg::PROD_W-1:hcg_pkg::QUO_W];
         sh_in   = dividend[hcg_pkg::QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = hcg_pkg::CNT_W'(hcg_pkg::QUO_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? diff[hcg_pkg::DUR_W-1:0] : trial[hcg_pkg::DUR_W-1:0];
         sh_in  = {sh_ff[hcg_pkg::QUO_W-2:0], fits};
         cnt_in = cnt_ff - hcg_pkg::CNT_W'(1);
         if (cnt_ff == hcg_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      sh_ff  <= sh_in;
   end

   assign done     = done_ff;
   assign quotient = sh_ff;

endmodule

`default_nettype wire
